// File: src/perspective_plane_projection_top_defines.svh
// assertion macros shared by the projection block
`ifndef PERSPECTIVE_PLANE_PROJECTION_TOP_DEFINES_SVH
`define PERSPECTIVE_PLANE_PROJECTION_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PPP_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define PPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PPP_ASSERT(lbl, clk, rst_n, expr, msg)
`define PPP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/ppp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int CFG_W         = 32;
    localparam int ADDR_W        = 5;
    localparam int DW            = 33;  // p - v
    localparam int SW            = 68;  // dot product sums
    localparam int MAGW          = 67;  // magnitudes of num and den
    localparam int QW            = 63;  // alpha magnitude bits
    localparam int QDEPTH        = 8;

    typedef enum logic [2:0] {
        REG_NORMAL_X = 3'd0,
        REG_NORMAL_Y = 3'd1,
        REG_NORMAL_Z = 3'd2,
        REG_VIEW_X   = 3'd3,
        REG_VIEW_Y   = 3'd4,
        REG_VIEW_Z   = 3'd5,
        REG_RHS      = 3'd6,
        REG_MARGIN   = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LOW      = 2'd1,
        ST_ZERO_DEN = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [CFG_W-1:0] normal_x;
        logic signed [CFG_W-1:0] normal_y;
        logic signed [CFG_W-1:0] normal_z;
        logic signed [CFG_W-1:0] view_x;
        logic signed [CFG_W-1:0] view_y;
        logic signed [CFG_W-1:0] view_z;
        logic signed [CFG_W-1:0] plane_rhs;
        logic signed [CFG_W-1:0] margin;
    } t_cfg;

    typedef struct packed {
        logic zero_den;
        logic num_zero;
        logic num_neg;
        logic negq;
        logic ovf;
        logic last;
    } t_cls;

    typedef struct packed {
        t_cls                 cls;
        logic [MAGW-1:0]      rem;
        logic [QW-1:0]        nlo;
        logic [MAGW-1:0]      den;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic signed [DW-1:0] dz;
    } t_item;

endpackage
`default_nettype wire

// File: src/perspective_plane_projection_top.sv
// channel   | valid   | stall   | payload
// ----------+---------+---------+----------------------------------------------
// vertex in | i_valid | o_stall | i_point_x/y/z, i_last_point
// result    | o_valid | i_stall | o_proj_x/y/z, o_status, o_last_out
// config    | psel/penable/pwrite, paddr, pwdata, prdata, pready
//
// one word per cycle sustained while o_stall and i_stall stay low; a word passes the front
// pipeline, waits in the queue, then runs the 63-stage quotient pipeline (one bit per stage)
// the front never stalls; o_stall rises when front and queue together hold 8 words
// i_stall, while o_valid is high, freezes the whole back pipeline including the output register
// synchronous active-low reset clears valid bits, queue pointers and counts, and loads config defaults
`timescale 1ns / 1ps
`default_nettype none
module perspective_plane_projection_top #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [4:0]          paddr,
    input  wire [31:0]         pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire signed [31:0]  i_point_x,
    input  wire signed [31:0]  i_point_y,
    input  wire signed [31:0]  i_point_z,
    input  wire                i_last_point,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_proj_x,
    output logic signed [31:0] o_proj_y,
    output logic signed [31:0] o_proj_z,
    output logic [1:0]         o_status,
    output logic               o_last_out
);
    import ppp_pkg::*;

    localparam int OW = $clog2(QDEPTH + 1);

    t_cfg          cfg;
    logic          fr_valid;
    t_item         fr_item;
    logic [$bits(t_item)-1:0] q_data;
    logic          q_empty;
    logic          back_en;
    logic          pop;
    logic          accept;
    logic          back_vld;
    t_status       st;
    logic [OW-1:0] r_occ;

    ppp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_occ >= OW'(QDEPTH));

    ppp_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_valid      (accept),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_last_point (i_last_point),
        .o_valid      (fr_valid),
        .o_item       (fr_item)
    );

    ppp_fifo #(.WIDTH($bits(t_item)), .DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_data  (fr_item),
        .i_pop   (pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign back_en = !back_vld || !i_stall;
    assign pop     = back_en && !q_empty;

    // words in the front pipeline plus the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (accept && !pop) begin
            r_occ <= r_occ + 1'b1;
        end else if (pop && !accept) begin
            r_occ <= r_occ - 1'b1;
        end
    end

    ppp_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_en       (back_en),
        .i_valid    (pop),
        .i_item     (t_item'(q_data)),
        .o_valid    (back_vld),
        .o_proj_x   (o_proj_x),
        .o_proj_y   (o_proj_y),
        .o_proj_z   (o_proj_z),
        .o_status   (st),
        .o_last_out (o_last_out)
    );

    assign o_valid  = back_vld;
    assign o_status = st;
endmodule
`default_nettype wire

// File: src/ppp_regs.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_regs (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [ppp_pkg::ADDR_W-1:0]    paddr,
    input  wire [ppp_pkg::CFG_W-1:0]     pwdata,
    output logic [ppp_pkg::CFG_W-1:0]    prdata,
    output logic                         pready,
    output ppp_pkg::t_cfg                o_cfg
);
    import ppp_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.normal_x  <= '0;
            r_cfg.normal_y  <= '0;
            r_cfg.normal_z  <= 32'sd65536;
            r_cfg.view_x    <= '0;
            r_cfg.view_y    <= '0;
            r_cfg.view_z    <= '0;
            r_cfg.plane_rhs <= '0;
            r_cfg.margin    <= 32'sd66;
        end else if (wr) begin
            unique case (idx)
                REG_NORMAL_X: r_cfg.normal_x  <= pwdata;
                REG_NORMAL_Y: r_cfg.normal_y  <= pwdata;
                REG_NORMAL_Z: r_cfg.normal_z  <= pwdata;
                REG_VIEW_X:   r_cfg.view_x    <= pwdata;
                REG_VIEW_Y:   r_cfg.view_y    <= pwdata;
                REG_VIEW_Z:   r_cfg.view_z    <= pwdata;
                REG_RHS:      r_cfg.plane_rhs <= pwdata;
                REG_MARGIN:   r_cfg.margin    <= pwdata;
                default:      r_cfg           <= r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_NORMAL_X: prdata = r_cfg.normal_x;
            REG_NORMAL_Y: prdata = r_cfg.normal_y;
            REG_NORMAL_Z: prdata = r_cfg.normal_z;
            REG_VIEW_X:   prdata = r_cfg.view_x;
            REG_VIEW_Y:   prdata = r_cfg.view_y;
            REG_VIEW_Z:   prdata = r_cfg.view_z;
            REG_RHS:      prdata = r_cfg.plane_rhs;
            REG_MARGIN:   prdata = r_cfg.margin;
            default:      prdata = '0;
        endcase
    end
endmodule
`default_nettype wire

// File: src/ppp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_front #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  ppp_pkg::t_cfg                i_cfg,
    input  wire                          i_valid,
    input  wire signed [31:0]            i_point_x,
    input  wire signed [31:0]            i_point_y,
    input  wire signed [31:0]            i_point_z,
    input  wire                          i_last_point,
    output logic                         o_valid,
    output ppp_pkg::t_item               o_item
);
    import ppp_pkg::*;

    localparam int NW = MAGW + FRAC_BITS;
    localparam int HW = NW - QW;

    logic signed [DW-1:0]   r_a_d [3];
    logic signed [DW-1:0]   r_b_d [3];
    logic signed [DW-1:0]   r_c_d [3];
    logic signed [DW-1:0]   r_d_d [3];
    logic signed [64:0]     r_b_dn [3];
    logic signed [63:0]     r_b_vn [3];
    logic signed [SW-1:0]   r_c_num;
    logic signed [SW-1:0]   r_c_den;
    logic [MAGW-1:0]        r_d_nmag;
    logic [MAGW-1:0]        r_d_dmag;
    logic                   r_d_num_neg;
    logic                   r_d_den_neg;
    logic                   r_d_num_zero;
    logic                   r_d_den_zero;
    logic [4:0]             r_last;
    logic [4:0]             r_vld;
    t_item                  r_e_item;

    logic signed [CFG_W-1:0] pt [3];
    logic signed [CFG_W-1:0] vw [3];
    logic signed [CFG_W-1:0] nm [3];
    logic signed [SW-1:0]    n_num_abs;
    logic signed [SW-1:0]    n_den_abs;
    logic [NW-1:0]           nfull;
    logic [HW-1:0]           nhi;

    assign pt[0] = i_point_x;
    assign pt[1] = i_point_y;
    assign pt[2] = i_point_z;
    assign vw[0] = i_cfg.view_x;
    assign vw[1] = i_cfg.view_y;
    assign vw[2] = i_cfg.view_z;
    assign nm[0] = i_cfg.normal_x;
    assign nm[1] = i_cfg.normal_y;
    assign nm[2] = i_cfg.normal_z;

    assign n_num_abs = r_c_num[SW-1] ? -r_c_num : r_c_num;
    assign n_den_abs = r_c_den[SW-1] ? -r_c_den : r_c_den;
    assign nfull     = {r_d_nmag, {FRAC_BITS{1'b0}}};
    assign nhi       = nfull[NW-1:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[3:0], i_last_point};
        for (int k = 0; k < 3; k++) begin
            r_a_d[k]  <= DW'(pt[k]) - DW'(vw[k]);
            r_b_dn[k] <= r_a_d[k] * nm[k];
            r_b_vn[k] <= vw[k] * nm[k];
            r_b_d[k]  <= r_a_d[k];
            r_c_d[k]  <= r_b_d[k];
            r_d_d[k]  <= r_c_d[k];
        end
        r_c_den <= SW'(r_b_dn[0]) + SW'(r_b_dn[1]) + SW'(r_b_dn[2]);
        r_c_num <= (SW'(i_cfg.plane_rhs) <<< FRAC_BITS)
                   - SW'(r_b_vn[0]) - SW'(r_b_vn[1]) - SW'(r_b_vn[2]);

        r_d_nmag     <= n_num_abs[MAGW-1:0];
        r_d_dmag     <= n_den_abs[MAGW-1:0];
        r_d_num_neg  <= r_c_num[SW-1];
        r_d_den_neg  <= r_c_den[SW-1];
        r_d_num_zero <= (r_c_num == '0);
        r_d_den_zero <= (r_c_den == '0);

        // quotient saturates when num << F reaches den << 63
        r_e_item.cls.zero_den <= r_d_den_zero;
        r_e_item.cls.num_zero <= r_d_num_zero;
        r_e_item.cls.num_neg  <= r_d_num_neg;
        r_e_item.cls.negq     <= r_d_num_neg ^ r_d_den_neg;
        r_e_item.cls.ovf      <= MAGW'(nhi) >= r_d_dmag;
        r_e_item.cls.last     <= r_last[3];
        r_e_item.rem          <= MAGW'(nhi);
        r_e_item.nlo          <= nfull[QW-1:0];
        r_e_item.den          <= r_d_dmag;
        r_e_item.dx           <= r_d_d[0];
        r_e_item.dy           <= r_d_d[1];
        r_e_item.dz           <= r_d_d[2];
    end

    assign o_valid = r_vld[4];
    assign o_item  = r_e_item;
endmodule
`default_nettype wire

// File: src/ppp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "perspective_plane_projection_top_defines.svh"
module ppp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ppp_pkg::QDEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire [WIDTH-1:0]   i_data,
    input  wire               i_pop,
    output logic [WIDTH-1:0]  o_data,
    output logic              o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= nxt(r_wr);
            if (i_pop)  r_rd <= nxt(r_rd);
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);

    `PPP_ASSERT(a_no_overflow, i_clk, i_rst_n, !i_push || i_pop || r_count < CW'(DEPTH), "push into full queue")
    `PPP_ASSERT(a_no_underflow, i_clk, i_rst_n, !i_pop || r_count != '0, "pop from empty queue")
    `PPP_ASSERT_NEXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "count did not follow push")
endmodule
`default_nettype wire

// File: src/ppp_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_back #(
    parameter int FRAC_BITS = ppp_pkg::FRAC_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  ppp_pkg::t_cfg          i_cfg,
    input  wire                    i_en,
    input  wire                    i_valid,
    input  ppp_pkg::t_item         i_item,
    output logic                   o_valid,
    output logic signed [31:0]     o_proj_x,
    output logic signed [31:0]     o_proj_y,
    output logic signed [31:0]     o_proj_z,
    output ppp_pkg::t_status       o_status,
    output logic                   o_last_out
);
    import ppp_pkg::*;

    localparam int PW = 64 + DW;

    // divider pipeline, one quotient bit per stage
    logic                  r_dv_vld [QW];
    logic [MAGW-1:0]       r_dv_rem [QW];
    logic [QW-1:0]         r_dv_nlo [QW];
    logic [QW-1:0]         r_dv_q   [QW];
    logic [MAGW-1:0]       r_dv_den [QW];
    logic [3*DW-1:0]       r_dv_d   [QW];
    t_cls                  r_dv_cls [QW];

    logic [MAGW-1:0]       s_rem [QW];
    logic [QW-1:0]         s_nlo [QW];
    logic [QW-1:0]         s_q   [QW];
    logic [MAGW-1:0]       s_den [QW];
    logic [3*DW-1:0]       s_d   [QW];
    t_cls                  s_cls [QW];
    logic                  s_vld [QW];
    logic [MAGW:0]         s_rs  [QW];
    logic [MAGW:0]         s_df  [QW];

    logic [2:0]            r_m_vld;
    t_cls                  r_m_cls [3];
    logic [3*DW-1:0]       r_m_d   [3];
    logic signed [63:0]    r_m1_alpha;
    t_status               r_m_st  [3];
    logic signed [65:0]    r_m2_plo [3];
    logic signed [64:0]    r_m2_phi [3];
    logic signed [PW-1:0]  r_m3_prod [3];

    logic                  r_out_vld;
    logic signed [31:0]    r_out [3];
    t_status               r_out_st;
    logic                  r_out_last;

    logic [63:0]           mag;
    logic signed [63:0]    alpha;
    logic signed [DW-1:0]  d1 [3];
    logic signed [DW-1:0]  d3 [3];
    logic signed [31:0]    vw [3];
    logic signed [PW-1:0]  sum [3];
    logic signed [31:0]    res [3];

    assign vw[0] = i_cfg.view_x;
    assign vw[1] = i_cfg.view_y;
    assign vw[2] = i_cfg.view_z;

    always_comb begin
        for (int j = 0; j < QW; j++) begin
            if (j == 0) begin
                s_rem[j] = i_item.rem;
                s_nlo[j] = i_item.nlo;
                s_q[j]   = '0;
                s_den[j] = i_item.den;
                s_d[j]   = {i_item.dx, i_item.dy, i_item.dz};
                s_cls[j] = i_item.cls;
                s_vld[j] = i_valid;
            end else begin
                s_rem[j] = r_dv_rem[j-1];
                s_nlo[j] = r_dv_nlo[j-1];
                s_q[j]   = r_dv_q[j-1];
                s_den[j] = r_dv_den[j-1];
                s_d[j]   = r_dv_d[j-1];
                s_cls[j] = r_dv_cls[j-1];
                s_vld[j] = r_dv_vld[j-1];
            end
            s_rs[j] = {s_rem[j], s_nlo[j][QW-1]};
            s_df[j] = s_rs[j] - {1'b0, s_den[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < QW; j++) r_dv_vld[j] <= 1'b0;
            r_m_vld   <= '0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            for (int j = 0; j < QW; j++) r_dv_vld[j] <= s_vld[j];
            r_m_vld   <= {r_m_vld[1:0], r_dv_vld[QW-1]};
            r_out_vld <= r_m_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < QW; j++) begin
                // restoring step: remainder stays below den
                if (s_rs[j] >= {1'b0, s_den[j]}) begin
                    r_dv_rem[j] <= s_df[j][MAGW-1:0];
                    r_dv_q[j]   <= {s_q[j][QW-2:0], 1'b1};
                end else begin
                    r_dv_rem[j] <= s_rs[j][MAGW-1:0];
                    r_dv_q[j]   <= {s_q[j][QW-2:0], 1'b0};
                end
                r_dv_nlo[j] <= {s_nlo[j][QW-2:0], 1'b0};
                r_dv_den[j] <= s_den[j];
                r_dv_d[j]   <= s_d[j];
                r_dv_cls[j] <= s_cls[j];
            end
        end
    end

    assign mag   = r_dv_cls[QW-1].ovf ? {1'b0, {QW{1'b1}}} : {1'b0, r_dv_q[QW-1]};
    assign alpha = r_dv_cls[QW-1].negq ? -$signed(mag) : $signed(mag);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            d1[k] = r_m_d[0][(2-k)*DW +: DW];
            d3[k] = r_m_d[2][(2-k)*DW +: DW];
            sum[k] = (r_m3_prod[k] >>> FRAC_BITS) + PW'(vw[k]);
            if (r_m_cls[2].zero_den) begin
                if (r_m_cls[2].num_zero || d3[k] == '0) res[k] = vw[k];
                else if (r_m_cls[2].num_neg == d3[k][DW-1]) res[k] = 32'sh7fffffff;
                else res[k] = 32'sh80000000;
            end else if (sum[k][PW-1:31] != '0 && sum[k][PW-1:31] != '1) begin
                res[k] = sum[k][PW-1] ? 32'sh80000000 : 32'sh7fffffff;
            end else begin
                res[k] = sum[k][31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1_alpha <= alpha;
            r_m_cls[0] <= r_dv_cls[QW-1];
            r_m_d[0]   <= r_dv_d[QW-1];
            if (r_dv_cls[QW-1].zero_den)                     r_m_st[0] <= ST_ZERO_DEN;
            else if (alpha <= 64'($signed(i_cfg.margin)))    r_m_st[0] <= ST_LOW;
            else                                             r_m_st[0] <= ST_OK;
            for (int s = 1; s < 3; s++) begin
                r_m_cls[s] <= r_m_cls[s-1];
                r_m_d[s]   <= r_m_d[s-1];
                r_m_st[s]  <= r_m_st[s-1];
            end
            // alpha split in halves to keep each multiply near 32 bits
            for (int k = 0; k < 3; k++) begin
                r_m2_plo[k]  <= $signed({1'b0, r_m1_alpha[31:0]}) * d1[k];
                r_m2_phi[k]  <= $signed(r_m1_alpha[63:32]) * d1[k];
                r_m3_prod[k] <= (PW'(r_m2_phi[k]) <<< 32) + PW'(r_m2_plo[k]);
                r_out[k]     <= res[k];
            end
            r_out_st   <= r_m_st[2];
            r_out_last <= r_m_cls[2].last;
        end
    end

    assign o_valid    = r_out_vld;
    assign o_proj_x   = r_out[0];
    assign o_proj_y   = r_out[1];
    assign o_proj_z   = r_out[2];
    assign o_status   = r_out_st;
    assign o_last_out = r_out_last;
endmodule
`default_nettype wire
